[src/stb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Software timer bank package
// Field widths, command codes and period reset values shared by the timer
// bank, its channel interfaces and its top level.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int CMD_W         = 3;
    localparam int TIMER_IDX_W   = 3;
    localparam int TICK_W        = 8;
    localparam int MASK_W        = 8;
    localparam int PERIOD_W      = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int BANK_SIZE     = 8;

    localparam int NUM_TIMERS_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    typedef logic [CMD_W-1:0]       t_cmd;
    typedef logic [TIMER_IDX_W-1:0] t_timer_idx;
    typedef logic [TICK_W-1:0]      t_tick;
    typedef logic [MASK_W-1:0]      t_mask;
    typedef logic [PERIOD_W-1:0]    t_period;
    typedef logic [CFG_IDX_W-1:0]   t_cfg_idx;

    localparam t_cmd CMD_TICK    = 3'd0;
    localparam t_cmd CMD_START   = 3'd1;
    localparam t_cmd CMD_RESTART = 3'd2;
    localparam t_cmd CMD_STOP    = 3'd3;
    localparam t_cmd CMD_CLOSE   = 3'd4;

    localparam t_period PERIOD_RESET [BANK_SIZE] = '{
        16'd2, 16'd1, 16'd2000, 16'd10, 16'd20, 16'd20, 16'd14000, 16'd20
    };

endpackage
`default_nettype wire

[src/stb_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Software timer bank channels
// Valid/ready channels for command items, result items and period writes.
// ----------------------------------------------------------------------------
interface stb_item_if import stb_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cmd       command;
    t_timer_idx timer_index;
    t_tick      tick_count;

    modport source (output valid, output command, output timer_index,
                    output tick_count, input ready);
    modport sink   (input valid, input command, input timer_index,
                    input tick_count, output ready);
endinterface

interface stb_result_if import stb_pkg::*; ();
    logic  valid;
    logic  ready;
    t_mask running_mask;
    t_mask done_mask;

    modport source (output valid, output running_mask, output done_mask, input ready);
    modport sink   (input valid, input running_mask, input done_mask, output ready);
endinterface

interface stb_cfg_if import stb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_period  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[src/software_timer_bank_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Software timer bank
// Eight (NUM_TIMERS) software timers with programmable periods, served by one
// shared adder and comparator under a small sequencer.
// ----------------------------------------------------------------------------
// After a tick item is accepted, the block is not ready again until the
// single adder and comparator have visited every timer, one timer per
// cycle; start, restart, stop, close and unused commands pass once
// through the run state. The result item is held in an output register,
// so a new item is taken while an earlier result still waits. Period
// writes are accepted in any cycle and clear that timer's count.
module software_timer_bank_unit import stb_pkg::*; #(
    parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    stb_item_if.sink      i_item,
    stb_result_if.source  o_result,
    stb_cfg_if.sink       i_cfg
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
    localparam logic [IDX_W-1:0] LAST_PTR = IDX_W'(NUM_TIMERS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [IDX_W-1:0]       r_ptr, n_ptr;
    t_cmd                   r_cmd;
    t_tick                  r_ticks;
    logic                   r_idx_ok;
    logic [NUM_TIMERS-1:0]  r_running, n_running;
    logic [NUM_TIMERS-1:0]  r_done, n_done;
    logic [COUNT_WIDTH-1:0] r_count [NUM_TIMERS];
    t_period                r_period [NUM_TIMERS];
    logic                   r_out_valid, n_out_valid;
    t_mask                  r_out_running;
    t_mask                  r_out_done;

    logic                   item_acc;
    logic                   cfg_hit;
    logic                   out_load;
    logic                   cnt_we;
    logic [COUNT_WIDTH-1:0] cnt_wd;
    logic                   is_restart;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic [CMP_W-1:0]       per_ext;
    logic [COUNT_WIDTH-1:0] operand;
    logic [COUNT_WIDTH-1:0] sum;
    logic                   reached;

    assign item_acc = i_item.valid && i_item.ready;
    assign cfg_hit  = i_cfg.valid && (i_cfg.index < NUM_TIMERS);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_result.ready);

    assign i_item.ready          = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_result.valid        = r_out_valid;
    assign o_result.running_mask = r_out_running;
    assign o_result.done_mask    = r_out_done;

    // Shared unit: count plus ticks, or count minus period for a restart.
    assign is_restart = (r_cmd == CMD_RESTART);
    assign rd_count   = r_count[r_ptr];
    assign per_ext    = CMP_W'(r_period[r_ptr]);
    assign operand    = is_restart ? ~per_ext[COUNT_WIDTH-1:0] : COUNT_WIDTH'(r_ticks);
    assign sum        = rd_count + operand + COUNT_WIDTH'(is_restart);
    assign reached    = CMP_W'(sum) >= per_ext;

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_running = r_running;
        n_done    = r_done;
        cnt_we    = 1'b0;
        cnt_wd    = sum;
        case (r_state)
            S_IDLE: begin
                if (item_acc) begin
                    n_state = S_RUN;
                    n_ptr   = (i_item.command == CMD_TICK) ? '0
                                                           : i_item.timer_index[IDX_W-1:0];
                end
            end
            S_RUN: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_TICK: begin
                        if (r_running[r_ptr] && (r_ticks != '0)) begin
                            cnt_we = 1'b1;
                            if (reached) begin
                                n_running[r_ptr] = 1'b0;
                                n_done[r_ptr]    = 1'b1;
                            end
                        end
                        if (r_ptr != LAST_PTR) begin
                            n_state = S_RUN;
                            n_ptr   = r_ptr + IDX_W'(1);
                        end
                    end
                    CMD_START: begin
                        if (r_idx_ok) begin
                            cnt_we           = 1'b1;
                            cnt_wd           = '0;
                            n_running[r_ptr] = 1'b1;
                        end
                    end
                    CMD_RESTART: begin
                        if (r_idx_ok) begin
                            cnt_we           = 1'b1;
                            n_running[r_ptr] = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        if (r_idx_ok) begin
                            n_running[r_ptr] = 1'b0;
                            n_done[r_ptr]    = 1'b0;
                        end
                    end
                    CMD_CLOSE: begin
                        n_running = '0;
                        n_done    = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_running   <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_count[i]  <= '0;
                r_period[i] <= PERIOD_RESET[i];
            end
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_running   <= n_running;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (cnt_we) begin
                r_count[r_ptr] <= cnt_wd;
            end
            if (cfg_hit) begin
                r_period[i_cfg.index[IDX_W-1:0]] <= i_cfg.data;
                r_count[i_cfg.index[IDX_W-1:0]]  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_acc) begin
            r_cmd    <= i_item.command;
            r_ticks  <= i_item.tick_count;
            r_idx_ok <= (i_item.timer_index < NUM_TIMERS);
        end
        if (out_load) begin
            r_out_running <= MASK_W'(r_running);
            r_out_done    <= MASK_W'(r_done);
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_acc |=> (r_state == S_RUN))
        else $error("Accepted item did not start the sequencer.");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("Result appeared outside the completion state.");

    a_flags_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |=> ($stable(r_running) && $stable(r_done)))
        else $error("Timer flags changed while no item was being processed.");

    a_tick_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && (r_cmd == CMD_TICK)) |-> (r_ptr <= LAST_PTR))
        else $error("Tick sweep pointer left the timer range.");
`endif

endmodule
`default_nettype wire

[tb/tb_software_timer_bank_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer bank testbench
// Drives command items into the timer bank and keeps its own copy of the
// counts, periods and flags. It predicts the running and done masks of every
// item and compares them with the result items. Period registers are
// reprogrammed between phases while the bank is idle. Both channels idle at
// random, except in the last phase.
// ----------------------------------------------------------------------------
module tb_software_timer_bank_unit;
    import stb_pkg::*;

    localparam t_cmd CMD_MAX        = '1;
    localparam int   STALL_LIMIT    = 2000;
    localparam int   DRAIN_CYCLES   = 20;
    localparam int   PHASE_ITEMS    = 265;

    typedef struct packed {
        t_cmd       command;
        t_timer_idx timer_index;
        t_tick      tick_count;
    } timer_cmd_t;

    typedef struct packed {
        t_mask running;
        t_mask done;
    } timer_masks_t;

    logic i_clk;
    logic i_rst_n;

    stb_item_if   item_ch ();
    stb_result_if result_ch ();
    stb_cfg_if    cfg_ch ();

    software_timer_bank_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    timer_cmd_t   pending_cmds[$];
    timer_masks_t expected_masks[$];

    t_period                   model_period [BANK_SIZE];
    logic [COUNT_WIDTH_DEF-1:0] model_count [BANK_SIZE];
    t_mask                     model_running;
    t_mask                     model_done;

    int   items_queued;
    int   results_seen;
    int   mismatches;
    int   idle_cycles;
    int   send_gap;
    int   recv_stall;
    logic quiet;
    logic item_taken;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic timer_masks_t apply_timer_cmd(input timer_cmd_t c);
        timer_masks_t r;
        if (c.command == CMD_TICK) begin
            if (c.tick_count != '0) begin
                for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
                    if (model_running[i]) begin
                        model_count[i] = model_count[i] + c.tick_count;
                        if (model_count[i] >= model_period[i]) begin
                            model_running[i] = 1'b0;
                            model_done[i]    = 1'b1;
                        end
                    end
                end
            end
        end else if (c.command == CMD_START) begin
            model_count[c.timer_index]   = '0;
            model_running[c.timer_index] = 1'b1;
        end else if (c.command == CMD_RESTART) begin
            model_count[c.timer_index]   = model_count[c.timer_index]
                                           - model_period[c.timer_index];
            model_running[c.timer_index] = 1'b1;
        end else if (c.command == CMD_STOP) begin
            model_running[c.timer_index] = 1'b0;
            model_done[c.timer_index]    = 1'b0;
        end else if (c.command == CMD_CLOSE) begin
            model_running = '0;
            model_done    = '0;
        end
        r.running = model_running;
        r.done    = model_done;
        return r;
    endfunction

    function automatic timer_cmd_t make_cmd(input t_cmd c, input int idx, input int ticks);
        timer_cmd_t r;
        r.command     = c;
        r.timer_index = t_timer_idx'(idx);
        r.tick_count  = t_tick'(ticks);
        return r;
    endfunction

    function automatic timer_cmd_t random_cmd();
        timer_cmd_t r;
        int         roll;
        int         tick_roll;
        roll      = $urandom_range(0, 99);
        tick_roll = $urandom_range(0, 9);
        r.timer_index = t_timer_idx'($urandom_range(0, BANK_SIZE - 1));
        if (tick_roll == 0) begin
            r.tick_count = '0;
        end else if (tick_roll == 1) begin
            r.tick_count = '1;
        end else begin
            r.tick_count = t_tick'($urandom_range(1, 254));
        end
        if (roll < 50) begin
            r.command = CMD_TICK;
        end else if (roll < 70) begin
            r.command = CMD_START;
        end else if (roll < 80) begin
            r.command = CMD_RESTART;
        end else if (roll < 88) begin
            r.command = CMD_STOP;
        end else if (roll < 92) begin
            r.command = CMD_CLOSE;
        end else if (roll < 96) begin
            r.command = t_cmd'($urandom_range(CMD_CLOSE + 1, CMD_MAX));
        end else begin
            r = timer_cmd_t'($urandom);
        end
        return r;
    endfunction

    task automatic queue_cmd(input timer_cmd_t c);
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) begin
            queue_cmd(random_cmd());
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (results_seen != items_queued) begin
            @(negedge i_clk);
        end
    endtask

    task automatic program_period(input int idx, input int value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= t_cfg_idx'(idx);
        cfg_ch.data  <= t_period'(value);
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic program_all(input int lo, input int hi);
        for (int i = 0; i < BANK_SIZE; i++) begin
            program_period(i, $urandom_range(lo, hi));
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Command driver.
    always @(negedge i_clk) begin
        timer_cmd_t c;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            send_gap = 0;
        end else if (!item_ch.valid || item_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                item_ch.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(1, 12) - 1;
                item_ch.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                c = pending_cmds.pop_front();
                item_ch.valid       <= 1'b1;
                item_ch.command     <= c.command;
                item_ch.timer_index <= c.timer_index;
                item_ch.tick_count  <= c.tick_count;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            recv_stall = 0;
        end else if (quiet) begin
            result_ch.ready <= 1'b1;
        end else if (recv_stall > 0) begin
            recv_stall--;
            result_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            recv_stall = $urandom_range(1, 12) - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Monitor and checker.
    always @(posedge i_clk) begin
        timer_cmd_t   c;
        timer_masks_t want;
        if (!i_rst_n) begin
            item_taken   <= 1'b0;
            results_seen <= 0;
        end else begin
            item_taken <= item_ch.valid && item_ch.ready;
            if (result_ch.valid && result_ch.ready) begin
                results_seen <= results_seen + 1;
                if (expected_masks.size() == 0) begin
                    report_mismatch("result item with no command item pending");
                end else begin
                    want = expected_masks.pop_front();
                    if (result_ch.running_mask !== want.running) begin
                        report_mismatch($sformatf("running_mask %h, expected %h",
                                                  result_ch.running_mask, want.running));
                    end
                    if (result_ch.done_mask !== want.done) begin
                        report_mismatch($sformatf("done_mask %h, expected %h",
                                                  result_ch.done_mask, want.done));
                    end
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                c.command     = item_ch.command;
                c.timer_index = item_ch.timer_index;
                c.tick_count  = item_ch.tick_count;
                expected_masks.push_back(apply_timer_cmd(c));
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                model_period[cfg_ch.index] = cfg_ch.data;
                model_count[cfg_ch.index]  = '0;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                     || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("software_timer_bank_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_TICK;
        item_ch.timer_index = '0;
        item_ch.tick_count  = '0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        quiet               = 1'b0;
        items_queued        = 0;
        mismatches          = 0;
        for (int i = 0; i < BANK_SIZE; i++) begin
            model_period[i] = PERIOD_RESET[i];
            model_count[i]  = '0;
        end
        model_running = '0;
        model_done    = '0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Timer zero gets a zero period and timer one the largest one.
        program_period(0, 0);
        program_period(1, 16'hFFFF);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;

        queue_cmd(make_cmd(CMD_START, 0, 0));
        queue_cmd(make_cmd(CMD_TICK, 0, 0));
        queue_cmd(make_cmd(CMD_TICK, 7, 1));
        queue_cmd(make_cmd(CMD_START, 1, 255));
        queue_cmd(make_cmd(CMD_RESTART, 1, 0));
        queue_cmd(make_cmd(CMD_TICK, 0, 255));
        queue_cmd(make_cmd(CMD_START, 7, 0));
        queue_cmd(make_cmd(CMD_TICK, 0, 255));
        queue_cmd(make_cmd(CMD_RESTART, 7, 0));
        queue_cmd(make_cmd(CMD_STOP, 7, 0));
        queue_cmd(make_cmd(CMD_START, 2, 0));
        queue_cmd(make_cmd(CMD_RESTART, 3, 0));
        queue_cmd(make_cmd(CMD_TICK, 0, 10));
        queue_cmd(make_cmd(CMD_CLOSE, 0, 0));
        for (int c = CMD_CLOSE + 1; c <= CMD_MAX; c++) begin
            queue_cmd(make_cmd(t_cmd'(c), 7, 255));
        end
        queue_cmd(make_cmd(CMD_START, 5, 0));
        queue_cmd(make_cmd(CMD_STOP, 5, 0));
        queue_cmd(make_cmd(CMD_START, 6, 0));
        queue_cmd(make_cmd(CMD_TICK, 0, 128));
        queue_cmd(make_cmd(CMD_TICK, 0, 127));
        queue_cmd(make_cmd(CMD_RESTART, 0, 0));
        queue_cmd(make_cmd(CMD_STOP, 6, 0));
        queue_cmd(make_cmd(CMD_CLOSE, 7, 255));
        wait_idle();

        program_all(0, 0);
        queue_random(PHASE_ITEMS);
        wait_idle();

        program_all(16'hFFFF, 16'hFFFF);
        queue_random(PHASE_ITEMS);
        wait_idle();

        // The sender holds off halfway until every result is back.
        program_all(0, 600);
        queue_random(PHASE_ITEMS / 2);
        wait_idle();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        wait_idle();

        program_all(0, 16'hFFFF);
        queue_random(PHASE_ITEMS);
        wait_idle();

        program_all(0, 2000);
        quiet = 1'b1;
        queue_random(PHASE_ITEMS);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_masks.size() != 0) begin
            report_mismatch("command items left without a result item");
        end
        if (mismatches == 0) begin
            $display("software_timer_bank_unit: match");
        end else begin
            $display("software_timer_bank_unit: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
src/stb_pkg.sv
src/stb_if.sv
src/software_timer_bank_unit.sv
tb/tb_software_timer_bank_unit.sv
